@@ src/sha1c_pkg.sv @@
// sha1c_pkg: shared types and constants for the SHA-1 block compressor.
// Holds the word types, initial chaining values, round constants and the
// round control struct. No dependencies.
`default_nettype none

package sha1c_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] words_t;

  // H0 sits at index 0
  localparam words_t IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                           32'hefcdab89, 32'h67452301};

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam logic [1:0] STAGE_CH  = 2'd0;
  localparam logic [1:0] STAGE_PAR = 2'd1;
  localparam logic [1:0] STAGE_MAJ = 2'd2;
  localparam logic [1:0] STAGE_PR2 = 2'd3;

  typedef struct packed {
    logic       load;   // copy chaining value into A..E
    logic       step;   // run one round
    logic [1:0] stage;  // which group of twenty rounds
  } round_ctrl_t;

  function automatic word_t k_for_stage(input logic [1:0] stage);
    word_t k;
    case (stage)
      STAGE_CH:  k = K0;
      STAGE_PAR: k = K1;
      STAGE_MAJ: k = K2;
      STAGE_PR2: k = K3;
      default:   k = K0;
    endcase
    return k;
  endfunction

  function automatic word_t round_f(input logic [1:0] stage, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    case (stage)
      STAGE_CH:  f = (b & c) | (~b & d);
      STAGE_MAJ: f = (b & c) | (b & d) | (c & d);
      STAGE_PAR: f = b ^ c ^ d;
      STAGE_PR2: f = b ^ c ^ d;
      default:   f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

@@ src/sha1_block_compressor_core.sv @@
// sha1_block_compressor_core: SHA-1 compression of 16-word padded blocks.
// Words are taken one per cycle while the core is idle; after the sixteenth,
// 80 rounds run, each through ST_RD0 and ST_RND, with ST_RD1 between them for
// rounds 16-79 (schedule reads); ST_FIN then adds the result into the chaining
// value and registers the digest. Reset clears control and loads the
// chaining value with the SHA-1 initial values; the schedule memory is not cleared.
`default_nettype none

module sha1_block_compressor_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [31:0] message_word_i,
  input  wire         new_message_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] digest_word_0_o,
  output logic [31:0] digest_word_1_o,
  output logic [31:0] digest_word_2_o,
  output logic [31:0] digest_word_3_o,
  output logic [31:0] digest_word_4_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD0  = 3'd1;
  localparam logic [2:0] ST_RD1  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] wc_q, wc_d;
  logic [6:0] round_q, round_d;
  sha1c_pkg::words_t chain_q, chain_d;
  sha1c_pkg::words_t digest_q, digest_d;
  sha1c_pkg::words_t work;
  sha1c_pkg::words_t sum;
  sha1c_pkg::word_t  xor_q, xor_d;
  logic       out_valid_q, out_valid_d;

  logic             in_xfer;
  logic [3:0]       wc_eff;
  logic [3:0]       j;
  logic             expand;
  logic [1:0]       stage;
  logic             fin_go;
  sha1c_pkg::word_t w_rnd;
  sha1c_pkg::word_t w_xor;

  logic             mem_we;
  logic [3:0]       mem_waddr;
  sha1c_pkg::word_t mem_wdata;
  logic [3:0]       raddr_a, raddr_b;
  sha1c_pkg::word_t rdata_a, rdata_b;

  sha1c_pkg::round_ctrl_t rctrl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign wc_eff     = new_message_i ? 4'd0 : wc_q;
  assign j          = round_q[3:0];
  assign expand     = (round_q >= 7'd16);
  assign fin_go     = (state_q == ST_FIN) && !(out_valid_q && out_stall_i);

  always_comb begin
    if (round_q < 7'd20) begin
      stage = sha1c_pkg::STAGE_CH;
    end else if (round_q < 7'd40) begin
      stage = sha1c_pkg::STAGE_PAR;
    end else if (round_q < 7'd60) begin
      stage = sha1c_pkg::STAGE_MAJ;
    end else begin
      stage = sha1c_pkg::STAGE_PR2;
    end
  end

  // expanded word: w[j-16] ^ w[j-8] ^ w[j-14] ^ w[j-3], rotated by one
  assign w_xor = xor_q ^ rdata_a ^ rdata_b;
  assign w_rnd = expand ? {w_xor[30:0], w_xor[31]} : rdata_a;

  always_comb begin
    raddr_a = j;
    raddr_b = j + 4'd8;
    if (state_q == ST_RD1) begin
      raddr_a = j + 4'd2;
      raddr_b = j + 4'd13;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wc_eff;
    mem_wdata = message_word_i;
    if (in_xfer) begin
      mem_we = 1'b1;
    end else if (state_q == ST_RND && expand) begin
      mem_we    = 1'b1;
      mem_waddr = j;
      mem_wdata = w_rnd;
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      sum[i] = chain_q[i] + work[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    wc_d        = wc_q;
    round_d     = round_q;
    chain_d     = chain_q;
    digest_d    = digest_q;
    xor_d       = xor_q;
    out_valid_d = out_valid_q && out_stall_i;
    rctrl.load  = 1'b0;
    rctrl.step  = 1'b0;
    rctrl.stage = stage;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (new_message_i) begin
            chain_d = sha1c_pkg::IV;
          end
          wc_d = wc_eff + 4'd1;
          if (wc_eff == 4'd15) begin
            rctrl.load = 1'b1;
            round_d    = '0;
            state_d    = ST_RD0;
          end
        end
      end
      ST_RD0: begin
        state_d = expand ? ST_RD1 : ST_RND;
      end
      ST_RD1: begin
        xor_d   = rdata_a ^ rdata_b;
        state_d = ST_RND;
      end
      ST_RND: begin
        rctrl.step = 1'b1;
        if (round_q == 7'd79) begin
          round_d = '0;
          state_d = ST_FIN;
        end else begin
          round_d = round_q + 7'd1;
          state_d = ST_RD0;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          chain_d     = sum;
          digest_d    = sum;
          out_valid_d = 1'b1;
          wc_d        = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wc_q        <= '0;
      round_q     <= '0;
      chain_q     <= sha1c_pkg::IV;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wc_q        <= wc_d;
      round_q     <= round_d;
      chain_q     <= chain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digest_q <= digest_d;
    xor_q    <= xor_d;
  end

  sha1c_sched_mem u_sched_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  sha1c_round_unit u_round_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rctrl),
    .chain_i (chain_q),
    .w_i     (w_rnd),
    .work_o  (work)
  );

  assign out_valid_o     = out_valid_q;
  assign digest_word_0_o = digest_q[0];
  assign digest_word_1_o = digest_q[1];
  assign digest_word_2_o = digest_q[2];
  assign digest_word_3_o = digest_q[3];
  assign digest_word_4_o = digest_q[4];

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    round_q <= 7'd79)
    else $error("round counter out of range");

  a_digest_is_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> digest_word_0_o == chain_q[0] &&
                           digest_word_4_o == chain_q[4])
    else $error("digest differs from chaining value");

  a_fin_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> state_q == ST_IDLE && wc_q == 4'd0 && out_valid_q)
    else $error("block finish did not return to idle");

endmodule

`default_nettype wire

@@ src/sha1c_sched_mem.sv @@
// sha1c_sched_mem: 16 x 32 message schedule window.
// One write port, two read ports with registered read data.
// Uses sha1c_pkg for the word type.
`default_nettype none

module sha1c_sched_mem (
  input  wire                 clk_i,
  input  wire                 we_i,
  input  wire  [3:0]          waddr_i,
  input  wire sha1c_pkg::word_t wdata_i,
  input  wire  [3:0]          raddr_a_i,
  input  wire  [3:0]          raddr_b_i,
  output sha1c_pkg::word_t    rdata_a_o,
  output sha1c_pkg::word_t    rdata_b_o
);

  sha1c_pkg::word_t mem [16];
  sha1c_pkg::word_t rdata_a_q;
  sha1c_pkg::word_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

@@ src/sha1c_round_unit.sv @@
// sha1c_round_unit: working registers A..E and the SHA-1 round datapath.
// One round per step; loads from the chaining value at block start.
// Uses sha1c_pkg for types, round function and round constants.
`default_nettype none

module sha1c_round_unit (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire sha1c_pkg::round_ctrl_t ctrl_i,
  input  wire sha1c_pkg::words_t      chain_i,
  input  wire sha1c_pkg::word_t       w_i,
  output sha1c_pkg::words_t           work_o
);

  sha1c_pkg::words_t work_q, work_d;
  sha1c_pkg::word_t  t;

  always_comb begin
    t = {work_q[0][26:0], work_q[0][31:27]}
      + sha1c_pkg::round_f(ctrl_i.stage, work_q[1], work_q[2], work_q[3])
      + work_q[4] + w_i + sha1c_pkg::k_for_stage(ctrl_i.stage);
    work_d = work_q;
    if (ctrl_i.load) begin
      work_d = chain_i;
    end else if (ctrl_i.step) begin
      work_d[4] = work_q[3];
      work_d[3] = work_q[2];
      work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
      work_d[1] = work_q[0];
      work_d[0] = t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
    end else begin
      work_q <= work_d;
    end
  end

  assign work_o = work_q;

endmodule

`default_nettype wire
